### sv/rci_pkg.sv
package rci_pkg;

  // field widths and fixed-point format
  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int HALF_W     = DATA_WIDTH;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int D_W        = 4 * DATA_WIDTH;
  localparam int ROOT_W     = 2 * DATA_WIDTH;
  localparam int RAD_W      = DATA_WIDTH - 1;
  localparam int T_W        = DATA_WIDTH - 1;
  localparam int TAG_W      = 12;
  localparam int NUM_W      = PROD_W + 1;
  localparam int DV_W       = PROD_W + T_W + 1;

  // pipeline depth of each section
  localparam int FRONT_STAGES = 7;
  localparam int SQ_STAGES    = ROOT_W;
  localparam int DIV_STAGES   = T_W + 2;
  localparam int CO_STAGES    = 2;
  localparam int LATENCY      = FRONT_STAGES + SQ_STAGES + DIV_STAGES + CO_STAGES;

  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] origin_x;
    logic signed [DATA_WIDTH-1:0] origin_y;
    logic signed [DATA_WIDTH-1:0] origin_z;
    logic signed [DATA_WIDTH-1:0] dir_x;
    logic signed [DATA_WIDTH-1:0] dir_y;
    logic signed [DATA_WIDTH-1:0] dir_z;
    logic [TAG_W-1:0]             pixel_col;
    logic [TAG_W-1:0]             pixel_row;
  } ray_in_t;

  typedef struct packed {
    logic                         hit;
    logic [T_W-1:0]               hit_t;
    logic signed [DATA_WIDTH-1:0] hit_x;
    logic signed [DATA_WIDTH-1:0] hit_y;
    logic signed [DATA_WIDTH-1:0] hit_z;
    logic [TAG_W-1:0]             out_col;
    logic [TAG_W-1:0]             out_row;
  } ray_out_t;

  // per-ray values carried down the pipeline
  typedef struct packed {
    ray_in_t           ray;
    logic [PROD_W-1:0] a;
    logic [PROD_W-1:0] gmag;
    logic              gneg;
    logic              miss;
  } ray_ctx_t;

  // clamp a widened coordinate to the signed field range
  function automatic logic signed [DATA_WIDTH-1:0] sat_coord(
    input logic signed [PROD_W:0] v
  );
    logic signed [PROD_W:0] hi_lim;
    logic signed [PROD_W:0] lo_lim;
    hi_lim = (PROD_W+1)'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}));
    lo_lim = (PROD_W+1)'($signed({1'b1, {(DATA_WIDTH-1){1'b0}}}));
    if (v > hi_lim) begin
      return {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else if (v < lo_lim) begin
      return {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      return v[DATA_WIDTH-1:0];
    end
  endfunction

endpackage

### sv/rci_front.sv
// Quadratic coefficients and discriminant, seven stages.
module rci_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  rci_pkg::ray_in_t         in_ray,
  input  logic [rci_pkg::RAD_W-1:0] radius,
  output logic                     out_vld,
  output rci_pkg::ray_ctx_t        out_ctx,
  output logic [rci_pkg::D_W-1:0]  out_disc
);
  import rci_pkg::*;

  // stage 1: squares and cross products
  logic                     s1_vld_r;
  ray_in_t                  s1_ray_r;
  logic signed [PROD_W-1:0] s1_dxx_r, s1_dyy_r, s1_oxdx_r, s1_oydy_r, s1_oxx_r, s1_oyy_r;
  logic [PROD_W-1:0]        s1_r2_r;

  // stage 2: a, h, |o|^2
  logic                     s2_vld_r;
  ray_in_t                  s2_ray_r;
  logic [PROD_W-1:0]        s2_a_r, s2_sq_r, s2_r2_r;
  logic signed [PROD_W:0]   s2_h_r;

  // stage 3: magnitudes and signs
  logic                     s3_vld_r;
  ray_ctx_t                 s3_ctx_r;
  logic [PROD_W-1:0]        s3_cmag_r;
  logic                     s3_cneg_r;

  // stage 4: partial products
  logic                     s4_vld_r;
  ray_ctx_t                 s4_ctx_r;
  logic                     s4_cneg_r;
  logic [PROD_W-1:0]        s4_hll_r, s4_hlh_r, s4_hhh_r;
  logic [PROD_W-1:0]        s4_all_r, s4_alh_r, s4_ahl_r, s4_ahh_r;

  // stage 5: middle terms
  logic                     s5_vld_r;
  ray_ctx_t                 s5_ctx_r;
  logic                     s5_cneg_r;
  logic [PROD_W-1:0]        s5_hll_r, s5_hhh_r, s5_all_r, s5_ahh_r;
  logic [PROD_W:0]          s5_hmid_r, s5_amid_r;

  // stage 6: full products h^2 and a*|c|
  logic                     s6_vld_r;
  ray_ctx_t                 s6_ctx_r;
  logic                     s6_cneg_r;
  logic [D_W-1:0]           s6_h2_r, s6_ac_r;

  // stage 7: discriminant
  logic                     s7_vld_r;
  ray_ctx_t                 s7_ctx_r;
  logic [D_W-1:0]           s7_disc_r;

  logic signed [PROD_W:0]   h_neg;
  logic [PROD_W-1:0]        hmag;
  logic [D_W-1:0]           disc_nxt;
  logic                     dmiss_nxt;
  ray_ctx_t                 s7_ctx_nxt;

  always_comb begin
    h_neg = -s2_h_r;
    hmag  = s2_h_r[PROD_W] ? h_neg[PROD_W-1:0] : s2_h_r[PROD_W-1:0];
  end

  always_comb begin
    disc_nxt  = s6_h2_r - s6_ac_r;
    dmiss_nxt = 1'b0;
    if (s6_cneg_r) begin
      disc_nxt = s6_h2_r + s6_ac_r;
    end else if (s6_h2_r < s6_ac_r) begin
      dmiss_nxt = 1'b1;
    end
    s7_ctx_nxt      = s6_ctx_r;
    s7_ctx_nxt.miss = s6_ctx_r.miss | dmiss_nxt;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    s1_ray_r  <= in_ray;
    s1_dxx_r  <= $signed(in_ray.dir_x) * $signed(in_ray.dir_x);
    s1_dyy_r  <= $signed(in_ray.dir_y) * $signed(in_ray.dir_y);
    s1_oxdx_r <= $signed(in_ray.origin_x) * $signed(in_ray.dir_x);
    s1_oydy_r <= $signed(in_ray.origin_y) * $signed(in_ray.dir_y);
    s1_oxx_r  <= $signed(in_ray.origin_x) * $signed(in_ray.origin_x);
    s1_oyy_r  <= $signed(in_ray.origin_y) * $signed(in_ray.origin_y);
    s1_r2_r   <= PROD_W'(radius) * PROD_W'(radius);

    s2_ray_r <= s1_ray_r;
    s2_a_r   <= unsigned'(s1_dxx_r) + unsigned'(s1_dyy_r);
    s2_h_r   <= (PROD_W+1)'(s1_oxdx_r) + (PROD_W+1)'(s1_oydy_r);
    s2_sq_r  <= unsigned'(s1_oxx_r) + unsigned'(s1_oyy_r);
    s2_r2_r  <= s1_r2_r;

    s3_ctx_r.ray  <= s2_ray_r;
    s3_ctx_r.a    <= s2_a_r;
    s3_ctx_r.gmag <= hmag;
    s3_ctx_r.gneg <= !s2_h_r[PROD_W] && (s2_h_r != '0);
    s3_ctx_r.miss <= (s2_a_r == '0);
    s3_cneg_r     <= s2_sq_r < s2_r2_r;
    s3_cmag_r     <= (s2_sq_r < s2_r2_r) ? (s2_r2_r - s2_sq_r) : (s2_sq_r - s2_r2_r);

    s4_ctx_r  <= s3_ctx_r;
    s4_cneg_r <= s3_cneg_r;
    s4_hll_r  <= PROD_W'(s3_ctx_r.gmag[HALF_W-1:0]) * PROD_W'(s3_ctx_r.gmag[HALF_W-1:0]);
    s4_hlh_r  <= PROD_W'(s3_ctx_r.gmag[HALF_W-1:0]) * PROD_W'(s3_ctx_r.gmag[PROD_W-1:HALF_W]);
    s4_hhh_r  <= PROD_W'(s3_ctx_r.gmag[PROD_W-1:HALF_W]) * PROD_W'(s3_ctx_r.gmag[PROD_W-1:HALF_W]);
    s4_all_r  <= PROD_W'(s3_ctx_r.a[HALF_W-1:0]) * PROD_W'(s3_cmag_r[HALF_W-1:0]);
    s4_alh_r  <= PROD_W'(s3_ctx_r.a[HALF_W-1:0]) * PROD_W'(s3_cmag_r[PROD_W-1:HALF_W]);
    s4_ahl_r  <= PROD_W'(s3_ctx_r.a[PROD_W-1:HALF_W]) * PROD_W'(s3_cmag_r[HALF_W-1:0]);
    s4_ahh_r  <= PROD_W'(s3_ctx_r.a[PROD_W-1:HALF_W]) * PROD_W'(s3_cmag_r[PROD_W-1:HALF_W]);

    s5_ctx_r  <= s4_ctx_r;
    s5_cneg_r <= s4_cneg_r;
    s5_hll_r  <= s4_hll_r;
    s5_hhh_r  <= s4_hhh_r;
    s5_all_r  <= s4_all_r;
    s5_ahh_r  <= s4_ahh_r;
    s5_hmid_r <= {s4_hlh_r, 1'b0};
    s5_amid_r <= (PROD_W+1)'(s4_alh_r) + (PROD_W+1)'(s4_ahl_r);

    s6_ctx_r  <= s5_ctx_r;
    s6_cneg_r <= s5_cneg_r;
    s6_h2_r   <= {s5_hhh_r, s5_hll_r} + (D_W'(s5_hmid_r) << HALF_W);
    s6_ac_r   <= {s5_ahh_r, s5_all_r} + (D_W'(s5_amid_r) << HALF_W);

    s7_ctx_r  <= s7_ctx_nxt;
    s7_disc_r <= disc_nxt;
  end

  assign out_vld  = s7_vld_r;
  assign out_ctx  = s7_ctx_r;
  assign out_disc = s7_disc_r;

endmodule

### sv/rci_sqrt.sv
// Integer square root, one result bit per pipeline stage.
module rci_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  rci_pkg::ray_ctx_t          in_ctx,
  input  logic [rci_pkg::D_W-1:0]    in_disc,
  output logic                       out_vld,
  output rci_pkg::ray_ctx_t          out_ctx,
  output logic [rci_pkg::ROOT_W-1:0] out_root
);
  import rci_pkg::*;

  logic           vld_r  [SQ_STAGES];
  ray_ctx_t       ctx_r  [SQ_STAGES];
  logic [D_W-1:0] rem_r  [SQ_STAGES];
  logic [D_W-1:0] root_r [SQ_STAGES];

  logic [D_W-1:0] rem_in   [SQ_STAGES];
  logic [D_W-1:0] root_in  [SQ_STAGES];
  logic [D_W-1:0] bit_k    [SQ_STAGES];
  logic [D_W-1:0] trial    [SQ_STAGES];
  logic [D_W-1:0] rem_nxt  [SQ_STAGES];
  logic [D_W-1:0] root_nxt [SQ_STAGES];

  // each stage tries one root bit: rem >= root + bit
  always_comb begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        rem_in[k]  = in_disc;
        root_in[k] = '0;
      end else begin
        rem_in[k]  = rem_r[k-1];
        root_in[k] = root_r[k-1];
      end
      bit_k[k] = D_W'(1) << (D_W - 2 - 2 * k);
      trial[k] = root_in[k] + bit_k[k];
      if (rem_in[k] >= trial[k]) begin
        rem_nxt[k]  = rem_in[k] - trial[k];
        root_nxt[k] = (root_in[k] >> 1) + bit_k[k];
      end else begin
        rem_nxt[k]  = rem_in[k];
        root_nxt[k] = root_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < SQ_STAGES; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    ctx_r[0] <= in_ctx;
    for (int k = 1; k < SQ_STAGES; k++) begin
      ctx_r[k] <= ctx_r[k-1];
    end
    for (int k = 0; k < SQ_STAGES; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_ctx  = ctx_r[SQ_STAGES-1];
  assign out_root = root_r[SQ_STAGES-1][ROOT_W-1:0];

endmodule

### sv/rci_div.sv
// Root selection, range check and restoring divide for t.
module rci_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  rci_pkg::ray_ctx_t          in_ctx,
  input  logic [rci_pkg::ROOT_W-1:0] in_root,
  output logic                       out_vld,
  output rci_pkg::ray_ctx_t          out_ctx,
  output logic [rci_pkg::T_W-1:0]    out_t
);
  import rci_pkg::*;

  // root select stage
  logic             n_vld_r;
  ray_ctx_t         n_ctx_r;
  logic [NUM_W-1:0] n_num_r;
  logic [NUM_W-1:0] num_nxt;
  logic             nmiss_nxt;
  ray_ctx_t         n_ctx_nxt;

  // saturation check stage
  logic             c_vld_r;
  ray_ctx_t         c_ctx_r;
  logic [DV_W-1:0]  c_rem_r;
  logic             c_sat_r;

  // divide stages
  logic             vld_r [T_W];
  ray_ctx_t         ctx_r [T_W];
  logic             sat_r [T_W];
  logic [DV_W-1:0]  rem_r [T_W];
  logic [T_W-1:0]   q_r   [T_W];

  logic [DV_W-1:0]   rem_in  [T_W];
  logic [T_W-1:0]    q_in    [T_W];
  logic [PROD_W-1:0] a_in    [T_W];
  logic [DV_W-1:0]   dvs     [T_W];
  logic [DV_W-1:0]   rem_nxt [T_W];
  logic [T_W-1:0]    q_nxt   [T_W];

  // nearer root unless negative, else the farther one
  always_comb begin
    num_nxt   = '0;
    nmiss_nxt = 1'b0;
    if (!in_ctx.gneg) begin
      if (in_ctx.gmag >= in_root) begin
        num_nxt = NUM_W'(in_ctx.gmag) - NUM_W'(in_root);
      end else begin
        num_nxt = NUM_W'(in_ctx.gmag) + NUM_W'(in_root);
      end
    end else if (in_root >= in_ctx.gmag) begin
      num_nxt = NUM_W'(in_root) - NUM_W'(in_ctx.gmag);
    end else begin
      nmiss_nxt = 1'b1;
    end
    n_ctx_nxt      = in_ctx;
    n_ctx_nxt.miss = in_ctx.miss | nmiss_nxt;
  end

  // quotient bit T_W-1-j per stage j
  always_comb begin
    for (int j = 0; j < T_W; j++) begin
      if (j == 0) begin
        rem_in[j] = c_rem_r;
        q_in[j]   = '0;
        a_in[j]   = c_ctx_r.a;
      end else begin
        rem_in[j] = rem_r[j-1];
        q_in[j]   = q_r[j-1];
        a_in[j]   = ctx_r[j-1].a;
      end
      dvs[j] = DV_W'(a_in[j]) << (T_W - 1 - j);
      if (rem_in[j] >= dvs[j]) begin
        rem_nxt[j] = rem_in[j] - dvs[j];
        q_nxt[j]   = q_in[j] | (T_W'(1) << (T_W - 1 - j));
      end else begin
        rem_nxt[j] = rem_in[j];
        q_nxt[j]   = q_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      for (int j = 0; j < T_W; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else begin
      n_vld_r  <= in_vld;
      c_vld_r  <= n_vld_r;
      vld_r[0] <= c_vld_r;
      for (int j = 1; j < T_W; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    n_ctx_r <= n_ctx_nxt;
    n_num_r <= num_nxt;

    c_ctx_r <= n_ctx_r;
    c_rem_r <= DV_W'({n_num_r, {FRAC_BITS{1'b0}}});
    c_sat_r <= DV_W'({n_num_r, {FRAC_BITS{1'b0}}}) >= (DV_W'(n_ctx_r.a) << T_W);

    ctx_r[0] <= c_ctx_r;
    sat_r[0] <= c_sat_r;
    for (int j = 1; j < T_W; j++) begin
      ctx_r[j] <= ctx_r[j-1];
      sat_r[j] <= sat_r[j-1];
    end
    for (int j = 0; j < T_W; j++) begin
      rem_r[j] <= rem_nxt[j];
      q_r[j]   <= q_nxt[j];
    end
  end

  assign out_vld = vld_r[T_W-1];
  assign out_ctx = ctx_r[T_W-1];
  assign out_t   = sat_r[T_W-1] ? {T_W{1'b1}} : q_r[T_W-1];

endmodule

### sv/rci_coord.sv
// Hit point: o + floor(d * t), clamped; two stages.
module rci_coord (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  rci_pkg::ray_ctx_t       in_ctx,
  input  logic [rci_pkg::T_W-1:0] in_t,
  output logic                    out_vld,
  output rci_pkg::ray_out_t       out_res
);
  import rci_pkg::*;

  logic                     m_vld_r;
  ray_ctx_t                 m_ctx_r;
  logic [T_W-1:0]           m_t_r;
  logic signed [PROD_W-1:0] m_px_r, m_py_r, m_pz_r;

  logic                     o_vld_r;
  ray_out_t                 o_res_r;
  ray_out_t                 res_nxt;

  logic signed [DATA_WIDTH-1:0] t_s;
  assign t_s = $signed({1'b0, in_t});

  // add origin, clamp, zero on miss
  always_comb begin
    res_nxt         = '0;
    res_nxt.out_col = m_ctx_r.ray.pixel_col;
    res_nxt.out_row = m_ctx_r.ray.pixel_row;
    if (!m_ctx_r.miss) begin
      res_nxt.hit   = 1'b1;
      res_nxt.hit_t = m_t_r;
      res_nxt.hit_x = sat_coord((PROD_W+1)'($signed(m_ctx_r.ray.origin_x))
                                + (PROD_W+1)'(m_px_r >>> FRAC_BITS));
      res_nxt.hit_y = sat_coord((PROD_W+1)'($signed(m_ctx_r.ray.origin_y))
                                + (PROD_W+1)'(m_py_r >>> FRAC_BITS));
      res_nxt.hit_z = sat_coord((PROD_W+1)'($signed(m_ctx_r.ray.origin_z))
                                + (PROD_W+1)'(m_pz_r >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      m_vld_r <= in_vld;
      o_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_ctx_r <= in_ctx;
    m_t_r   <= in_t;
    m_px_r  <= $signed(in_ctx.ray.dir_x) * t_s;
    m_py_r  <= $signed(in_ctx.ray.dir_y) * t_s;
    m_pz_r  <= $signed(in_ctx.ray.dir_z) * t_s;
    o_res_r <= res_nxt;
  end

  assign out_vld = o_vld_r;
  assign out_res = o_res_r;

endmodule

### sv/ray_cylinder_intersect_unit.sv
// Channel   Direction  Handshake                  Payload
// in        input      start, busy                in_data  (ray_in_t)
// out       output     out_valid (one-cycle)      out_data (ray_out_t)
// cfg       input      cfg_valid, cfg_ready       cfg_data (radius, Q15.16)
//
// One ray per cycle; each ray passes 7 front stages, a 64-stage square root,
// 33 stages of root select and divide, then 2 coordinate stages to out_valid.
// busy stays low: the pipeline never stops, and results cannot be held off.
// Synchronous active-low reset clears all valid bits and sets radius to 1.0.
// cfg_ready is always high; write the radius only with no ray in flight.
module ray_cylinder_intersect_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  rci_pkg::ray_in_t          in_data,
  output logic                      out_valid,
  output rci_pkg::ray_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rci_pkg::RAD_W-1:0] cfg_data
);
  import rci_pkg::*;

  logic [RAD_W-1:0]  radius_r;
  logic              fr_vld, sq_vld, dv_vld;
  ray_ctx_t          fr_ctx, sq_ctx, dv_ctx;
  logic [D_W-1:0]    fr_disc;
  logic [ROOT_W-1:0] sq_root;
  logic [T_W-1:0]    dv_t;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_data;
    end
  end

  rci_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_ray   (in_data),
    .radius   (radius_r),
    .out_vld  (fr_vld),
    .out_ctx  (fr_ctx),
    .out_disc (fr_disc)
  );

  rci_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_ctx   (fr_ctx),
    .in_disc  (fr_disc),
    .out_vld  (sq_vld),
    .out_ctx  (sq_ctx),
    .out_root (sq_root)
  );

  rci_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sq_vld),
    .in_ctx  (sq_ctx),
    .in_root (sq_root),
    .out_vld (dv_vld),
    .out_ctx (dv_ctx),
    .out_t   (dv_t)
  );

  rci_coord u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (dv_vld),
    .in_ctx  (dv_ctx),
    .in_t    (dv_t),
    .out_vld (out_valid),
    .out_res (out_data)
  );

endmodule

### sv/rci_checker.sv
module rci_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input rci_pkg::ray_in_t          in_data,
  input logic                      out_valid,
  input rci_pkg::ray_out_t         out_data
);
  import rci_pkg::*;

  // reset empties the pipeline
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // a miss carries zero result fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_t == '0 && out_data.hit_x == '0
      && out_data.hit_y == '0 && out_data.hit_z == '0)
    else $error("miss with nonzero fields");

  // every result comes from an earlier accepted transaction
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching transaction");

  // tags pass through in order
  a_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_col == $past(in_data.pixel_col, LATENCY)
      && out_data.out_row == $past(in_data.pixel_row, LATENCY))
    else $error("pixel tag mismatch");

endmodule

bind ray_cylinder_intersect_unit rci_checker u_rci_checker (.*);
